[rtl/pip_pkg.sv]
package pip_pkg;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_TEST  = 1'b1
    } action_t;

    localparam int unsigned IDX_W   = 8;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned MIN_POLY = 3;

endpackage

[rtl/pip_if.sv]
interface pip_item_if #(
    parameter int COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    pip_pkg::action_t              action;
    logic [pip_pkg::IDX_W-1:0]     vertex_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;

    modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_result_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

interface pip_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [pip_pkg::CNT_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

[rtl/pip_ram.sv]
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/point_in_polygon_test.sv]
// write transaction: vertex stored at the clock edge of acceptance
// test transaction with n >= 3 vertices: one read of the one-port vertex memory per vertex
// plus the closing vertex, each edge then passing the s0 and s1 registers, drain and done states
// test transaction with n < 3: straight to the done state, which waits for an earlier result to be taken
// one transaction at a time: the next is accepted only once the done state returns to idle
// reset clears control and vertex_count; the vertex memory is not cleared
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pip_item_if.sink     item,
    pip_result_if.source result,
    pip_cfg_if.sink      cfg
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int VW = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [pip_pkg::CNT_W-1:0] count_reg;
    logic [NW-1:0]             n_sat;
    logic [NW-1:0]             cnt_reg, cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      rd_first_reg, rd_first_next;
    logic                      inside_reg, inside_next;
    logic                      res_vld_reg, res_vld_next;
    logic                      res_data_reg, res_data_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_addr;
    logic [VW-1:0]             ram_wdata;
    logic [VW-1:0]             ram_rdata;

    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] xi, yi;

    logic                 s0_vld_reg, s0_vld_next;
    logic                 s0_strad_reg, s0_strad_next;
    logic                 s0_dyneg_reg, s0_dyneg_next;
    logic signed [DW-1:0] s0_a_reg, s0_b_reg, s0_c_reg, s0_d_reg;
    logic signed [DW-1:0] s0_a_next, s0_b_next, s0_c_next, s0_d_next;

    logic                 s1_vld_reg, s1_vld_next;
    logic                 s1_strad_reg, s1_dyneg_reg;
    logic signed [PW-1:0] s1_ab_reg, s1_cd_reg;
    logic signed [PW-1:0] s1_ab_next, s1_cd_next;
    logic                 flip;

    logic item_acc;
    logic slot_ok;

    assign n_sat = (32'(count_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_reg);

    assign item.ready   = (state_reg == ST_IDLE);
    assign item_acc     = item.valid && item.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid      = res_vld_reg;
    assign result.inside_res = res_data_reg;

    assign slot_ok   = 32'(item.vertex_index) < MAX_VERTICES;
    assign ram_we    = item_acc && (item.action == pip_pkg::ACT_WRITE) && slot_ok;
    assign ram_wdata = {item.coord_y, item.coord_x};

    always_comb
    begin
        if (state_reg == ST_READ)
        begin
            if (cnt_reg == '0)
            begin
                ram_addr = AW'(n_sat - NW'(1));
            end
            else
            begin
                ram_addr = AW'(cnt_reg - NW'(1));
            end
        end
        else
        begin
            ram_addr = AW'(item.vertex_index);
        end
    end

    pip_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // edge from the previous vertex (j) to the current one (i)
    assign xi = $signed(ram_rdata[COORD_BITS-1:0]);
    assign yi = $signed(ram_rdata[VW-1:COORD_BITS]);

    always_comb
    begin
        s0_vld_next   = rd_vld_reg && !rd_first_reg;
        s0_strad_next = (yi > py_reg) != (prev_y_reg > py_reg);
        s0_a_next     = DW'(px_reg) - DW'(xi);
        s0_b_next     = DW'(prev_y_reg) - DW'(yi);
        s0_c_next     = DW'(prev_x_reg) - DW'(xi);
        s0_d_next     = DW'(py_reg) - DW'(yi);
        s0_dyneg_next = s0_b_next < 0;
        s1_vld_next   = s0_vld_reg;
        s1_ab_next    = PW'(s0_a_reg) * PW'(s0_b_reg);
        s1_cd_next    = PW'(s0_c_reg) * PW'(s0_d_reg);
    end

    // crossing right of the point, comparison flipped when prev_y - yi is negative
    assign flip = s1_vld_reg && s1_strad_reg &&
                  (s1_dyneg_reg ? (s1_ab_reg > s1_cd_reg) : (s1_ab_reg < s1_cd_reg));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_first_next = 1'b0;
        inside_next   = inside_reg ^ flip;
        res_vld_next  = res_vld_reg && !result.ready;
        res_data_next = res_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.action == pip_pkg::ACT_TEST))
                begin
                    inside_next = 1'b0;
                    cnt_next    = '0;
                    if (32'(n_sat) < pip_pkg::MIN_POLY)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                rd_vld_next   = 1'b1;
                rd_first_next = (cnt_reg == '0);
                cnt_next      = cnt_reg + NW'(1);
                if (cnt_reg == n_sat)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !s0_vld_reg && !s1_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_vld_reg || result.ready)
                begin
                    res_vld_next  = 1'b1;
                    res_data_next = inside_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            s0_vld_reg   <= 1'b0;
            s1_vld_reg   <= 1'b0;
            inside_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
            res_data_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
            s0_vld_reg   <= s0_vld_next;
            s1_vld_reg   <= s1_vld_next;
            inside_reg   <= inside_next;
            res_vld_reg  <= res_vld_next;
            res_data_reg <= res_data_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.vertex_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            px_reg <= item.coord_x;
            py_reg <= item.coord_y;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= xi;
            prev_y_reg <= yi;
        end
        s0_strad_reg <= s0_strad_next;
        s0_dyneg_reg <= s0_dyneg_next;
        s0_a_reg     <= s0_a_next;
        s0_b_reg     <= s0_b_next;
        s0_c_reg     <= s0_c_next;
        s0_d_reg     <= s0_d_next;
        s1_strad_reg <= s0_strad_reg;
        s1_dyneg_reg <= s0_dyneg_reg;
        s1_ab_reg    <= s1_ab_next;
        s1_cd_reg    <= s1_cd_next;
    end

    // no vertex write while a test walks the memory
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("vertex write outside idle");

    // edge pipeline only busy during a test
    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("edge pipeline active outside a test");

    // read counter never passes the vertex count
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (cnt_reg <= n_sat))
        else $error("read counter beyond vertex count");

    // a new result only comes out of the done state
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // leaving drain only with an empty pipeline
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && state_next == ST_DONE) |-> (!s1_vld_reg && !flip))
        else $error("drain left with edges in flight");

endmodule
